// File: sv/vsrle_pkg.sv
// shared types and constants for the volume slice run-length decoder
// no dependencies; imported by the interfaces and every module of the block
package vsrle_pkg;

    localparam int BYTE_W     = 8;
    localparam int RUN_W      = 7;
    localparam int SLICE_W    = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESSION_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_SIZE       = 2'd1;

    localparam logic                REG_MODE_RESET  = 1'b1;
    localparam logic [SLICE_W-1:0]  REG_SLICE_RESET = 25'd65536;

    // control byte layout
    localparam int                  CTRL_LIT_BIT = 7;
    localparam logic [RUN_W-1:0]    RUN_ZERO     = 7'd0;
    localparam logic [RUN_W-1:0]    RUN_ONE      = 7'd1;

    // most voxels a repeat run puts out on its value byte
    localparam logic [RUN_W-1:0]    MAX_BURST    = 7'd64;

    typedef enum logic [1:0] {
        PH_CTRL = 2'd0,
        PH_LIT  = 2'd1,
        PH_REP  = 2'd2
    } phase_t;

    typedef struct packed {
        logic               compression_mode;
        logic [SLICE_W-1:0] slice_size;
    } vsrle_cfg_t;

    // expansion command: cnt copies of value, then an optional single tail result
    typedef struct packed {
        logic [RUN_W-1:0]  cnt;
        logic [BYTE_W-1:0] value;
        logic              has_tail;
        logic [BYTE_W-1:0] tail_voxel;
        logic              tail_valid;
        logic              tail_eos;
    } vsrle_cmd_t;

endpackage

// File: sv/vsrle_ifs.sv
// channel interfaces of the volume slice run-length decoder
// depends on vsrle_pkg for field widths
interface vsrle_byte_if import vsrle_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface vsrle_voxel_if import vsrle_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] voxel;
    logic              voxel_valid;
    logic              end_of_slice;
    logic              last;

    modport source (output valid, output voxel, output voxel_valid,
                    output end_of_slice, output last, input ready);
    modport sink   (input valid, input voxel, input voxel_valid,
                    input end_of_slice, input last, output ready);
endinterface

interface vsrle_cfg_if import vsrle_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/vsrle_cfg_regs.sv
// configuration registers: compression mode and raw slice size
// depends on vsrle_pkg and vsrle_cfg_if
module vsrle_cfg_regs import vsrle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vsrle_cfg_if.sink   cfg,
    output vsrle_cfg_t  cfg_out
);

    logic               mode_reg;
    logic [SLICE_W-1:0] slice_size_reg;
    logic               wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= REG_MODE_RESET;
            slice_size_reg <= REG_SLICE_RESET;
        end
        else if (wr)
        begin
            if (cfg.index == REG_COMPRESSION_MODE)
            begin
                mode_reg <= cfg.data[0];
            end
            else if (cfg.index == REG_SLICE_SIZE)
            begin
                slice_size_reg <= cfg.data[SLICE_W-1:0];
            end
        end
    end

    assign cfg_out.compression_mode = mode_reg;
    assign cfg_out.slice_size       = slice_size_reg;

endmodule

// File: sv/vsrle_decode.sv
// decoder state and per-byte command build
// depends on vsrle_pkg; feeds vsrle_emit with at most one expansion command per byte
module vsrle_decode import vsrle_pkg::*;
#(
    parameter int MAX_SLICE_VOXELS = 16777216
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  vsrle_cfg_t        cfg,
    input  logic              accept,
    input  logic [BYTE_W-1:0] data_byte,
    output vsrle_cmd_t        cmd,
    output logic              cmd_load
);

    localparam int CNT_W = (MAX_SLICE_VOXELS > 1) ? $clog2(MAX_SLICE_VOXELS) : 1;
    localparam logic [SLICE_W-1:0] SLICE_CAP = SLICE_W'(MAX_SLICE_VOXELS);

    phase_t            phase_reg,   phase_next;
    logic [RUN_W-1:0]  run_reg,     run_next;
    logic [CNT_W-1:0]  raw_cnt_reg, raw_cnt_next;
    logic [BYTE_W-1:0] rep_val_reg, rep_val_next;

    logic               drain;
    phase_t             phase_eff;
    logic [RUN_W-1:0]   run_eff;
    logic [RUN_W-1:0]   run_dec;
    logic [RUN_W-1:0]   burst;
    logic [SLICE_W-1:0] limit;
    logic [CNT_W:0]     raw_inc;
    logic               raw_eos;

    always_comb
    begin
        // owed repeat voxels go out first unless a run is still open
        drain     = !(phase_reg == PH_LIT || phase_reg == PH_REP);
        phase_eff = drain ? PH_CTRL : phase_reg;
        run_eff   = drain ? RUN_ZERO : run_reg;
        run_dec   = run_eff - RUN_ONE;
        burst     = (run_eff > MAX_BURST) ? MAX_BURST : run_eff;
        limit     = (cfg.slice_size > SLICE_CAP) ? SLICE_CAP : cfg.slice_size;
        raw_inc   = {1'b0, raw_cnt_reg} + {{CNT_W{1'b0}}, 1'b1};
        raw_eos   = SLICE_W'(raw_inc) >= limit;

        phase_next   = phase_eff;
        run_next     = run_eff;
        raw_cnt_next = raw_cnt_reg;
        rep_val_next = rep_val_reg;

        cmd.cnt        = drain ? run_reg : RUN_ZERO;
        cmd.value      = rep_val_reg;
        cmd.has_tail   = 1'b0;
        cmd.tail_voxel = data_byte;
        cmd.tail_valid = 1'b1;
        cmd.tail_eos   = 1'b0;

        if (!cfg.compression_mode)
        begin
            cmd.has_tail = 1'b1;
            cmd.tail_eos = raw_eos;
            raw_cnt_next = raw_eos ? '0 : raw_inc[CNT_W-1:0];
        end
        else
        begin
            unique case (phase_eff)
                PH_CTRL:
                begin
                    if (data_byte[RUN_W-1:0] == RUN_ZERO)
                    begin
                        // end-of-slice marker
                        cmd.has_tail   = 1'b1;
                        cmd.tail_voxel = '0;
                        cmd.tail_valid = 1'b0;
                        cmd.tail_eos   = 1'b1;
                    end
                    else
                    begin
                        phase_next = data_byte[CTRL_LIT_BIT] ? PH_LIT : PH_REP;
                        run_next   = data_byte[RUN_W-1:0];
                    end
                end
                PH_LIT:
                begin
                    cmd.has_tail = 1'b1;
                    run_next     = run_dec;
                    if (run_dec == RUN_ZERO)
                    begin
                        phase_next = PH_CTRL;
                    end
                end
                PH_REP:
                begin
                    cmd.cnt      = burst;
                    cmd.value    = data_byte;
                    rep_val_next = data_byte;
                    run_next     = run_eff - burst;
                    phase_next   = PH_CTRL;
                end
                default:
                begin
                    phase_next = PH_CTRL;
                end
            endcase
        end
    end

    assign cmd_load = accept && ((cmd.cnt != RUN_ZERO) || cmd.has_tail);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_CTRL;
            run_reg     <= RUN_ZERO;
            raw_cnt_reg <= '0;
            rep_val_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            run_reg     <= run_next;
            raw_cnt_reg <= raw_cnt_next;
            rep_val_reg <= rep_val_next;
        end
    end

endmodule

// File: sv/vsrle_emit.sv
// command register and result register: expands one command into results
// depends on vsrle_pkg and vsrle_voxel_if
module vsrle_emit import vsrle_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  vsrle_cmd_t   cmd,
    input  logic         cmd_load,
    output logic         cmd_ready,
    vsrle_voxel_if.source vox
);

    vsrle_cmd_t        cmd_reg;
    logic              cmd_valid_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] voxel_reg,   voxel_next;
    logic              vvalid_reg,  vvalid_next;
    logic              eos_reg,     eos_next;
    logic              last_reg,    last_next;

    logic out_adv;
    logic cmd_fire;
    logic cmd_last;
    logic in_copies;

    always_comb
    begin
        out_adv   = !out_valid_reg || vox.ready;
        cmd_fire  = cmd_valid_reg && out_adv;
        in_copies = cmd_reg.cnt != RUN_ZERO;
        cmd_last  = in_copies ? (cmd_reg.cnt == RUN_ONE && !cmd_reg.has_tail) : 1'b1;

        if (in_copies)
        begin
            voxel_next  = cmd_reg.value;
            vvalid_next = 1'b1;
            eos_next    = 1'b0;
        end
        else
        begin
            voxel_next  = cmd_reg.tail_voxel;
            vvalid_next = cmd_reg.tail_valid;
            eos_next    = cmd_reg.tail_eos;
        end
        last_next = cmd_last;
    end

    // slot frees up in the same cycle its final result moves out
    assign cmd_ready = !cmd_valid_reg || (cmd_fire && cmd_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd_load)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (cmd_fire && cmd_last)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_load)
        begin
            cmd_reg <= cmd;
        end
        else if (cmd_fire && in_copies)
        begin
            cmd_reg.cnt <= cmd_reg.cnt - RUN_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            voxel_reg  <= voxel_next;
            vvalid_reg <= vvalid_next;
            eos_reg    <= eos_next;
            last_reg   <= last_next;
        end
    end

    assign vox.valid        = out_valid_reg;
    assign vox.voxel        = voxel_reg;
    assign vox.voxel_valid  = vvalid_reg;
    assign vox.end_of_slice = eos_reg;
    assign vox.last         = last_reg;

endmodule

// File: sv/volume_slice_rle_decoder.sv
// a result passes the command register and then the result register before it is on voxel_out
// throughput: one byte and one result per cycle while voxel_out is ready; a byte that yields
//   several results holds slice_in while they leave the command register, a run byte up to 64
// a control byte with nonzero count yields only the repeat voxels still owed from the run before
// reset: rst_n async low; mode run-length, slice size 65536, decoder expects control
module volume_slice_rle_decoder import vsrle_pkg::*;
#(
    parameter int MAX_SLICE_VOXELS = 16777216
)
(
    input  logic           clk,
    input  logic           rst_n,
    vsrle_byte_if.sink     slice_in,
    vsrle_voxel_if.source  voxel_out,
    vsrle_cfg_if.sink      cfg
);

    vsrle_cfg_t cfg_q;
    vsrle_cmd_t cmd;
    logic       cmd_load;
    logic       cmd_ready;
    logic       accept;

    assign slice_in.ready = cmd_ready;
    assign accept         = slice_in.valid && cmd_ready;

    vsrle_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_q)
    );

    vsrle_decode #(
        .MAX_SLICE_VOXELS (MAX_SLICE_VOXELS)
    ) u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_q),
        .accept    (accept),
        .data_byte (slice_in.data_byte),
        .cmd       (cmd),
        .cmd_load  (cmd_load)
    );

    vsrle_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_load  (cmd_load),
        .cmd_ready (cmd_ready),
        .vox       (voxel_out)
    );

endmodule

// File: sv/vsrle_checker.sv
// port-level checks for the volume slice run-length decoder
// depends on vsrle_pkg; bound to volume_slice_rle_decoder below
module vsrle_checker import vsrle_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] voxel,
    input logic              voxel_valid,
    input logic              end_of_slice,
    input logic              last
);

    // a stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(voxel) && $stable(last) && $stable(end_of_slice))
        else $error("stalled result changed");

    // the end marker is the last result of its byte and has a zero voxel
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !voxel_valid |-> end_of_slice && last && voxel == '0)
        else $error("malformed end-of-slice marker");

    // slice end is always the final result of its byte
    a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_slice |-> last)
        else $error("end of slice not last of its byte");

endmodule

bind volume_slice_rle_decoder vsrle_checker u_vsrle_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (voxel_out.valid),
    .out_ready    (voxel_out.ready),
    .voxel        (voxel_out.voxel),
    .voxel_valid  (voxel_out.voxel_valid),
    .end_of_slice (voxel_out.end_of_slice),
    .last         (voxel_out.last)
);
